// ===== sv/rotation_matrix_to_quaternion_defines.svh =====
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
// checks that a condition leads to a consequence in the next cycle
`define RMQ_ASSERT_NEXT(label, clk_s, rst_s, cond, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (cond) |=> (cons)) \
    else $error("rmq check failed");
// checks that a condition leads to a consequence in the same cycle
`define RMQ_ASSERT_NOW(label, clk_s, rst_s, cond, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (cond) |-> (cons)) \
    else $error("rmq check failed");
`endif

// ===== sv/rmq_pkg.sv =====
package rmq_pkg;
  localparam int FRAC_BITS = 16;
  localparam int MW = 18;
  localparam int PW = 20;
  localparam int MAGW = 36;
  localparam int SQW = 72;
  typedef logic signed [MW-1:0] m_t;
  typedef logic signed [PW-1:0] p_t;
  typedef struct packed {
    logic ok;
    p_t p0;
    p_t p1;
    p_t p2;
    p_t p3;
  } item_t;
endpackage

// ===== sv/rmq_front.sv =====
// rigidity check and branch choice, three register stages
module rmq_front import rmq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [15:0] tol,
  input  m_t m [9],
  output logic out_valid,
  output item_t out_item
);
  localparam int DW = 80;
  // stage 1: products
  logic v1, v2, v3;
  m_t a [9];
  logic signed [2*MW:0] d1 [6];
  logic signed [2*MW:0] c1 [3];
  logic [15:0] t1, t2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    a <= m;
    t1 <= tol;
    d1[0] <= m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
    d1[1] <= m[0]*m[3] + m[1]*m[4] + m[2]*m[5];
    d1[2] <= m[0]*m[6] + m[1]*m[7] + m[2]*m[8];
    d1[3] <= m[3]*m[3] + m[4]*m[4] + m[5]*m[5];
    d1[4] <= m[3]*m[6] + m[4]*m[7] + m[5]*m[8];
    d1[5] <= m[6]*m[6] + m[7]*m[7] + m[8]*m[8];
    c1[0] <= m[4]*m[8] - m[5]*m[7];
    c1[1] <= m[3]*m[8] - m[5]*m[6];
    c1[2] <= m[3]*m[7] - m[4]*m[6];
  end
  // stage 2: determinant terms and row checks
  m_t b [9];
  logic signed [DW-1:0] e2 [3];
  logic rows_ok;
  logic rows_ok_next;
  logic signed [DW-1:0] one2, tl2, dv;
  always_comb begin
    one2 = DW'(1) <<< (2*FRAC_BITS);
    tl2 = DW'(t1) <<< FRAC_BITS;
    rows_ok_next = 1'b1;
    for (int i = 0; i < 6; i++) begin
      dv = DW'(d1[i]);
      if (i == 0 || i == 3 || i == 5) dv = dv - one2;
      if ((dv < 0 ? -dv : dv) > tl2) rows_ok_next = 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    b <= a;
    t2 <= t1;
    rows_ok <= rows_ok_next;
    e2[0] <= DW'(a[0]) * DW'(c1[0]);
    e2[1] <= DW'(a[1]) * DW'(c1[1]);
    e2[2] <= DW'(a[2]) * DW'(c1[2]);
  end
  // stage 3: determinant check and branch
  logic signed [DW-1:0] det, dq;
  logic signed [PW-1:0] one, tr, arg;
  item_t it;
  always_comb begin
    det = e2[0] - e2[1] + e2[2];
    dq = (det >>> (2*FRAC_BITS)) - (DW'(1) <<< FRAC_BITS);
    one = PW'(1) <<< FRAC_BITS;
    tr = PW'(b[0]) + PW'(b[4]) + PW'(b[8]);
    if (tr > 0) begin
      arg = one + tr;
      it.p0 = arg; it.p1 = PW'(b[7]) - PW'(b[5]);
      it.p2 = PW'(b[2]) - PW'(b[6]); it.p3 = PW'(b[3]) - PW'(b[1]);
    end else if (b[0] > b[4] && b[0] > b[8]) begin
      arg = one + PW'(b[0]) - PW'(b[4]) - PW'(b[8]);
      it.p0 = PW'(b[7]) - PW'(b[5]); it.p1 = arg;
      it.p2 = PW'(b[1]) + PW'(b[3]); it.p3 = PW'(b[2]) + PW'(b[6]);
    end else if (b[4] > b[8]) begin
      arg = one + PW'(b[4]) - PW'(b[0]) - PW'(b[8]);
      it.p0 = PW'(b[2]) - PW'(b[6]); it.p1 = PW'(b[1]) + PW'(b[3]);
      it.p2 = arg; it.p3 = PW'(b[5]) + PW'(b[7]);
    end else begin
      arg = one + PW'(b[8]) - PW'(b[0]) - PW'(b[4]);
      it.p0 = PW'(b[3]) - PW'(b[1]); it.p1 = PW'(b[2]) + PW'(b[6]);
      it.p2 = PW'(b[5]) + PW'(b[7]); it.p3 = arg;
    end
    it.ok = rows_ok && ((dq < 0 ? -dq : dq) <= DW'(t2)) && (arg > 0);
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    out_item <= it;
  end
  assign out_valid = v3;
endmodule

// ===== sv/rmq_queue.sv =====
// short fifo between front and back
module rmq_queue import rmq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  item_t wdata,
  input  logic rd,
  output logic nonempty,
  output item_t rdata
);
  item_t buffer [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (wr) wp <= wp + 2'd1;
      if (rd) rp <= rp + 2'd1;
      cnt <= cnt + 3'(wr) - 3'(rd);
    end
    if (wr) buffer[wp] <= wdata;
  end
  assign nonempty = (cnt != 3'd0);
  assign rdata = buffer[rp];
endmodule

// ===== sv/rmq_back.sv =====
`include "rotation_matrix_to_quaternion_defines.svh"
// normalization pipeline: scale, square sum, sqrt, divide
module rmq_back import rmq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  item_t in_item,
  output logic out_valid,
  output m_t q [4],
  output logic ok_out
);
  localparam int SQS = 32;  // sqrt result bits
  localparam int QW = MAGW + FRAC_BITS + 1;
  // stage a: magnitudes and normalizing shift
  logic va;
  logic oka;
  logic [MAGW-1:0] mg [4];
  logic sg [4];
  logic [MAGW-1:0] mx, t_mg [4];
  logic [5:0] sh;
  always_comb begin
    mx = '0;
    for (int i = 0; i < 4; i++) begin
      logic signed [PW-1:0] pv;
      pv = (i == 0) ? in_item.p0 : (i == 1) ? in_item.p1 : (i == 2) ? in_item.p2 : in_item.p3;
      t_mg[i] = MAGW'(pv < 0 ? -pv : pv);
      if (t_mg[i] > mx) mx = t_mg[i];
    end
    sh = 6'd0;
    for (int k = 29; k >= 0; k--) begin
      if (mx[k] && mx < (MAGW'(1) << 29)) sh = (sh == 6'd0 && !(|(mx >> (k+1)))) ? 6'(29-k) : sh;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= in_valid;
    end
    oka <= in_item.ok;
    sg[0] <= in_item.p0 < 0; sg[1] <= in_item.p1 < 0;
    sg[2] <= in_item.p2 < 0; sg[3] <= in_item.p3 < 0;
    for (int i = 0; i < 4; i++) mg[i] <= t_mg[i] << sh;
  end
  // stage b: squares
  logic vb, okb;
  logic [SQW-1:0] sqr [4];
  logic [MAGW-1:0] mgb [4];
  logic sgb [4];
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
    okb <= oka; mgb <= mg; sgb <= sg;
    for (int i = 0; i < 4; i++) sqr[i] <= SQW'(mg[i]) * SQW'(mg[i]);
  end
  // stage c: sum
  logic vc, okc;
  logic [SQW-1:0] sum;
  logic [MAGW-1:0] mgc [4];
  logic sgc [4];
  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else begin
      vc <= vb;
    end
    okc <= okb; mgc <= mgb; sgc <= sgb;
    sum <= sqr[0] + sqr[1] + sqr[2] + sqr[3];
  end
  // pipelined sqrt by trial squaring, one result bit per stage
  logic sv_v [SQS+1];
  logic sv_ok [SQS+1];
  logic [SQW-1:0] sv_rem [SQS+1];
  logic [SQS-1:0] sv_root [SQS+1];
  logic [MAGW-1:0] sv_mg [SQS+1][4];
  logic sv_sg [SQS+1][4];
  assign sv_v[0] = vc; assign sv_ok[0] = okc; assign sv_rem[0] = sum;
  assign sv_root[0] = '0; assign sv_mg[0] = mgc; assign sv_sg[0] = sgc;
  for (genvar s = 0; s < SQS; s++) begin : g_sqrt
    logic [SQW-1:0] trial;
    logic [SQS-1:0] cand;
    assign cand = sv_root[s] | (SQS'(1) << (SQS-1-s));
    assign trial = SQW'(cand) * SQW'(cand);
    always_ff @(posedge clk) begin
      if (rst) begin
        sv_v[s+1] <= 1'b0;
      end else begin
        sv_v[s+1] <= sv_v[s];
      end
      sv_ok[s+1] <= sv_ok[s];
      sv_rem[s+1] <= sv_rem[s];
      sv_mg[s+1] <= sv_mg[s];
      sv_sg[s+1] <= sv_sg[s];
      sv_root[s+1] <= (trial <= sv_rem[s]) ? cand : sv_root[s];
    end
  end
  // pipelined division, one quotient bit per stage per lane
  localparam int DB = FRAC_BITS + 2;
  logic dv_v [DB+1];
  logic dv_ok [DB+1];
  logic [SQS-1:0] dv_len [DB+1];
  logic [QW-1:0] dv_rem [DB+1][4];
  logic [DB-1:0] dv_q [DB+1][4];
  logic dv_sg [DB+1][4];
  assign dv_v[0] = sv_v[SQS]; assign dv_ok[0] = sv_ok[SQS];
  assign dv_len[0] = sv_root[SQS];
  for (genvar i = 0; i < 4; i++) begin : g_init
    assign dv_rem[0][i] = (QW'(sv_mg[SQS][i]) << FRAC_BITS) + QW'(sv_root[SQS] >> 1);
    assign dv_q[0][i] = '0;
    assign dv_sg[0][i] = sv_sg[SQS][i];
  end
  for (genvar s = 0; s < DB; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[s+1] <= 1'b0;
      end else begin
        dv_v[s+1] <= dv_v[s];
      end
      dv_ok[s+1] <= dv_ok[s];
      dv_len[s+1] <= dv_len[s];
      for (int i = 0; i < 4; i++) begin
        dv_sg[s+1][i] <= dv_sg[s][i];
        if (dv_rem[s][i] >= (QW'(dv_len[s]) << (DB-1-s))) begin
          dv_rem[s+1][i] <= dv_rem[s][i] - (QW'(dv_len[s]) << (DB-1-s));
          dv_q[s+1][i] <= dv_q[s][i] | (DB'(1) << (DB-1-s));
        end else begin
          dv_rem[s+1][i] <= dv_rem[s][i];
          dv_q[s+1][i] <= dv_q[s][i];
        end
      end
    end
  end
  // saturate, sign, zero when not ok, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_v[DB];
    end
    ok_out <= dv_ok[DB];
    for (int i = 0; i < 4; i++) begin
      logic [DB-1:0] qs;
      qs = (dv_q[DB][i] > (DB'(1) << FRAC_BITS)) ? (DB'(1) << FRAC_BITS) : dv_q[DB][i];
      if (!dv_ok[DB]) q[i] <= '0;
      else q[i] <= dv_sg[DB][i] ? MW'(-$signed({1'b0, qs})) : MW'(qs);
    end
  end
  `RMQ_ASSERT_NEXT(a_va, clk, rst, in_valid, va)
  `RMQ_ASSERT_NEXT(a_vb, clk, rst, va, vb)
  `RMQ_ASSERT_NOW(a_ok, clk, rst, out_valid && !ok_out, q[0] == '0 && q[3] == '0)
endmodule

// ===== sv/rotation_matrix_to_quaternion.sv =====
// channel  | ports                               | timing
// config   | rigidity_tolerance_we, _wdata       | written at the edge, no wait
// matrix   | start, busy, r00..r22               | beat when start and not busy
// result   | done, quat_w..quat_z, orientation_ok| one-cycle strobe
// one matrix per cycle; 58 register stages (front 3, queue 1, back 3, sqrt 32,
// divide 18, output 1) lie between the accepting edge and done.
// busy stays low after reset; reset is synchronous; results cannot be stalled.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic rigidity_tolerance_we,
  input  logic [15:0] rigidity_tolerance_wdata,
  input  logic start,
  output logic busy,
  input  logic signed [17:0] r00, r01, r02, r10, r11, r12, r20, r21, r22,
  output logic done,
  output logic signed [17:0] quat_w, quat_x, quat_y, quat_z,
  output logic orientation_ok
);
  logic [15:0] tol;
  always_ff @(posedge clk) begin
    if (rst) tol <= 16'd328;
    else if (rigidity_tolerance_we) tol <= rigidity_tolerance_wdata;
  end
  assign busy = 1'b0;
  m_t m [9];
  assign m[0] = r00; assign m[1] = r01; assign m[2] = r02;
  assign m[3] = r10; assign m[4] = r11; assign m[5] = r12;
  assign m[6] = r20; assign m[7] = r21; assign m[8] = r22;
  logic fv, qne;
  item_t fi, qi;
  rmq_front u_front (.clk, .rst, .in_valid(start && !busy),
    .tol, .m, .out_valid(fv), .out_item(fi));
  rmq_queue u_queue (.clk, .rst, .wr(fv), .wdata(fi), .rd(qne), .nonempty(qne), .rdata(qi));
  m_t q [4];
  rmq_back u_back (.clk, .rst, .in_valid(qne), .in_item(qi),
    .out_valid(done), .q, .ok_out(orientation_ok));
  assign quat_w = q[0]; assign quat_x = q[1]; assign quat_y = q[2]; assign quat_z = q[3];
endmodule

// ===== tb/sv/rmq_checker.sv =====
module rmq_checker (
  input  logic clk,
  input  logic rst,
  input  logic tol_we,
  input  logic [15:0] tol_wdata,
  input  logic start,
  input  logic busy,
  input  logic signed [17:0] r00, r01, r02, r10, r11, r12, r20, r21, r22,
  input  logic done,
  input  logic signed [17:0] quat_w, quat_x, quat_y, quat_z,
  input  logic orientation_ok,
  output int fail_count,
  output int pending
);
  localparam int FB = 16;

  typedef struct {
    logic signed [17:0] q[4];
    logic ok;
  } quat_t;

  quat_t expected_quats[$];
  logic [15:0] tolerance;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint floor_div(longint v, int k);
    longint unsigned a;
    if (v >= 0) return v >>> k;
    a = -v;
    return -longint'((a + ((64'd1 << k) - 1)) >> k);
  endfunction

  function automatic quat_t matrix_to_quat(longint m[9], logic [15:0] tol);
    quat_t res;
    longint tol2, d, det, dq, arg, p[4];
    longint unsigned mag[4], mx, sum, len, qv;
    bit rigid;
    res.ok = 0;
    for (int i = 0; i < 4; i++) res.q[i] = '0;
    tol2 = longint'(tol) << FB;
    rigid = 1;
    for (int i = 0; i < 3; i++)
      for (int j = i; j < 3; j++) begin
        d = m[3*i]*m[3*j] + m[3*i+1]*m[3*j+1] + m[3*i+2]*m[3*j+2];
        if (i == j) d -= 64'sd1 << (2*FB);
        if ((d < 0 ? -d : d) > tol2) rigid = 0;
      end
    det = m[0]*(m[4]*m[8] - m[5]*m[7]) - m[1]*(m[3]*m[8] - m[5]*m[6])
        + m[2]*(m[3]*m[7] - m[4]*m[6]);
    dq = floor_div(det, 2*FB) - (64'sd1 << FB);
    if ((dq < 0 ? -dq : dq) > longint'(tol)) rigid = 0;
    if (!rigid) return res;
    if (m[0] + m[4] + m[8] > 0) begin
      arg = (64'sd1 << FB) + m[0] + m[4] + m[8];
      p[0] = arg; p[1] = m[7]-m[5]; p[2] = m[2]-m[6]; p[3] = m[3]-m[1];
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      arg = (64'sd1 << FB) + m[0] - m[4] - m[8];
      p[0] = m[7]-m[5]; p[1] = arg; p[2] = m[1]+m[3]; p[3] = m[2]+m[6];
    end else if (m[4] > m[8]) begin
      arg = (64'sd1 << FB) + m[4] - m[0] - m[8];
      p[0] = m[2]-m[6]; p[1] = m[1]+m[3]; p[2] = arg; p[3] = m[5]+m[7];
    end else begin
      arg = (64'sd1 << FB) + m[8] - m[0] - m[4];
      p[0] = m[3]-m[1]; p[1] = m[2]+m[6]; p[2] = m[5]+m[7]; p[3] = arg;
    end
    if (arg <= 0) return res;
    mx = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = p[i] < 0 ? -p[i] : p[i];
      if (mag[i] > mx) mx = mag[i];
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 4; i++) mag[i] <<= 1;
    end
    sum = 0;
    for (int i = 0; i < 4; i++) sum += mag[i] * mag[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 4; i++) begin
      qv = ((mag[i] << FB) + (len >> 1)) / len;
      if (qv > (64'd1 << FB)) qv = 64'd1 << FB;
      res.q[i] = p[i] < 0 ? -qv[17:0] : qv[17:0];
    end
    res.ok = 1;
    return res;
  endfunction

  assign pending = expected_quats.size();

  always @(posedge clk) begin
    longint m[9];
    quat_t e;
    if (rst) begin
      tolerance <= 16'd328;
      fail_count <= 0;
    end else begin
      if (start && !busy) begin
        m = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
        expected_quats.push_back(matrix_to_quat(m, tolerance));
      end
      if (tol_we) tolerance <= tol_wdata;
      if (done) begin
        if (expected_quats.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat at %0t", $realtime);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_quats.pop_front();
          if (e.q[0] !== quat_w || e.q[1] !== quat_x || e.q[2] !== quat_y ||
              e.q[3] !== quat_z || e.ok !== orientation_ok) begin
            if (fail_count < 10)
              $display("mismatch: exp %0d %0d %0d %0d ok=%0d got %0d %0d %0d %0d ok=%0d",
                       e.q[0], e.q[1], e.q[2], e.q[3], e.ok,
                       quat_w, quat_x, quat_y, quat_z, orientation_ok);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  logic clk = 0;
  logic rst = 1;
  logic tol_we = 0;
  logic [15:0] tol_wdata = '0;
  logic start = 0;
  logic busy, done, orientation_ok;
  logic signed [17:0] r[9];
  logic signed [17:0] quat_w, quat_x, quat_y, quat_z;
  int fail_count, pending;
  longint cycles = 0;

  initial for (int i = 0; i < 9; i++) r[i] = '0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  rotation_matrix_to_quaternion u_dut (
    .clk(clk), .rst(rst),
    .rigidity_tolerance_we(tol_we), .rigidity_tolerance_wdata(tol_wdata),
    .start(start), .busy(busy),
    .r00(r[0]), .r01(r[1]), .r02(r[2]), .r10(r[3]), .r11(r[4]), .r12(r[5]),
    .r20(r[6]), .r21(r[7]), .r22(r[8]),
    .done(done), .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y),
    .quat_z(quat_z), .orientation_ok(orientation_ok)
  );

  rmq_checker u_checker (
    .clk(clk), .rst(rst), .tol_we(tol_we), .tol_wdata(tol_wdata),
    .start(start), .busy(busy),
    .r00(r[0]), .r01(r[1]), .r02(r[2]), .r10(r[3]), .r11(r[4]), .r12(r[5]),
    .r20(r[6]), .r21(r[7]), .r22(r[8]),
    .done(done), .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y),
    .quat_z(quat_z), .orientation_ok(orientation_ok),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL");
      $finish;
    end
  end

  int gap_left = 0;
  int burst_left = 0;

  // one beat, with bursts and random gaps before it
  task automatic send_matrix(input longint m[9]);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap_left > 0) begin
      start <= 0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    for (int i = 0; i < 9; i++) r[i] <= m[i][17:0];
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_tol(input logic [15:0] v);
    tol_we <= 1;
    tol_wdata <= v;
    @(posedge clk);
    tol_we <= 0;
  endtask

  // random rotation built from a random quaternion, truncated to q2.16
  function automatic void rot_from_quat(output longint m[9]);
    real a, b, c, d, n;
    a = $urandom_range(0, 2000) - 1000.0;
    b = $urandom_range(0, 2000) - 1000.0;
    c = $urandom_range(0, 2000) - 1000.0;
    d = $urandom_range(0, 2000) - 1000.0;
    n = $sqrt(a*a + b*b + c*c + d*d);
    if (n < 1.0) begin
      a = 1.0; n = 1.0;
    end
    a /= n; b /= n; c /= n; d /= n;
    m[0] = $rtoi((1 - 2*(c*c + d*d)) * 65536.0);
    m[1] = $rtoi(2*(b*c - a*d) * 65536.0);
    m[2] = $rtoi(2*(b*d + a*c) * 65536.0);
    m[3] = $rtoi(2*(b*c + a*d) * 65536.0);
    m[4] = $rtoi((1 - 2*(b*b + d*d)) * 65536.0);
    m[5] = $rtoi(2*(c*d - a*b) * 65536.0);
    m[6] = $rtoi(2*(b*d - a*c) * 65536.0);
    m[7] = $rtoi(2*(c*d + a*b) * 65536.0);
    m[8] = $rtoi((1 - 2*(b*b + c*c)) * 65536.0);
  endfunction

  function automatic longint rand18();
    return longint'($urandom_range(0, 262143)) - 131072;
  endfunction

  initial begin
    longint m[9];
    longint one;
    int sel;
    one = 65536;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // identity, axis half turns (each branch), diagonal ties, extremes
    m = '{one, 0, 0, 0, one, 0, 0, 0, one};   send_matrix(m);
    m = '{one, 0, 0, 0, -one, 0, 0, 0, -one}; send_matrix(m);
    m = '{-one, 0, 0, 0, one, 0, 0, 0, -one}; send_matrix(m);
    m = '{-one, 0, 0, 0, -one, 0, 0, 0, one}; send_matrix(m);
    m = '{0, -one, 0, one, 0, 0, 0, 0, one};  send_matrix(m);
    m = '{0, 0, one, 0, one, 0, -one, 0, 0};  send_matrix(m);
    m = '{one, 0, 0, 0, 0, -one, 0, one, 0};  send_matrix(m);
    m = '{-one, 0, 0, 0, 0, one, 0, one, 0};  send_matrix(m);
    m = '{0, one, 0, one, 0, 0, 0, 0, -one};  send_matrix(m);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};         send_matrix(m);
    m = '{131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071};
    send_matrix(m);
    m = '{-131072, -131072, -131072, -131072, -131072, -131072, -131072, -131072,
          -131072};
    send_matrix(m);
    m = '{one, 0, 0, 0, one, 0, 0, 0, -one};  send_matrix(m);
    m = '{one + 300, 0, 0, 0, one, 0, 0, 0, one}; send_matrix(m);
    m = '{one + 400, 0, 0, 0, one, 0, 0, 0, one}; send_matrix(m);
    drain();

    // zero tolerance, then full tolerance on degenerate and extreme matrices
    write_tol(16'd0);
    m = '{one, 0, 0, 0, one, 0, 0, 0, one};   send_matrix(m);
    m = '{-one, 0, 0, 0, -one, 0, 0, 0, one}; send_matrix(m);
    m = '{one + 1, 0, 0, 0, one, 0, 0, 0, one}; send_matrix(m);
    drain();
    write_tol(16'hFFFF);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};         send_matrix(m);
    m = '{-one, 0, 0, 0, -one, 0, 0, 0, -one}; send_matrix(m);
    m = '{131071, -131072, 131071, -131072, 131071, -131072, 131071, -131072, 131071};
    send_matrix(m);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_tol(16'd328);
        1: write_tol(16'd0);
        2: write_tol(16'd4);
        3: write_tol(16'd2000);
        default: write_tol(16'hFFFF);
      endcase
      for (int k = 0; k < 100; k++) begin
        sel = $urandom_range(0, 9);
        rot_from_quat(m);
        if (sel == 8) begin
          for (int i = 0; i < 9; i++) m[i] = rand18();
        end else if (sel == 9) begin
          m[$urandom_range(0, 8)] += longint'($urandom_range(0, 800)) - 400;
        end else if (sel == 7) begin
          // small perturbation in every entry
          for (int i = 0; i < 9; i++) m[i] += longint'($urandom_range(0, 6)) - 3;
        end
        for (int i = 0; i < 9; i++) begin
          if (m[i] > 131071) m[i] = 131071;
          if (m[i] < -131072) m[i] = -131072;
        end
        send_matrix(m);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+sv
sv/rmq_pkg.sv
sv/rmq_front.sv
sv/rmq_queue.sv
sv/rmq_back.sv
sv/rotation_matrix_to_quaternion.sv
tb/sv/rmq_checker.sv
tb/sv/tb_top.sv
